>>> src/tcw_pkg.sv
// tcw_pkg: shared types, codes and defaults for the text console writer
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 8;

    localparam int POS_W  = 11;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [7:0] CHR_BS    = 8'h08;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    localparam logic [7:0] ATTR_RESET = 8'h0F;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [7:0]       char_code;
        logic [IDX_W-1:0] cell_index;
    } tcw_req_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
    } tcw_result_t;

    typedef struct packed {
        logic       put;
        logic       home;
        logic [7:0] code;
    } tcw_cursor_cmd_t;

    typedef struct packed {
        logic wr_en;
        logic scroll;
    } tcw_cursor_stat_t;

endpackage

>>> src/text_console_char_writer.sv
// text_console_char_writer: text console engine, cell store plus cursor and sweep sequencer
// put and unused codes: result strobe in the cycle after the transfer, next transfer in that cycle
// read: result registered from S_READ, which takes the registered ram data; clear: store swept to blank
// put that scrolls: rows copied up one cell per cycle through the ram port, then the last row blanked
// reset: busy while the store is swept to blank 0x0F20, no result
// depends on tcw_pkg, tcw_cursor, tcw_cell_ram
`timescale 1ns / 1ps

module text_console_char_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int ROWS     = ROWS_DEF,
    parameter int TAB_STOP = TAB_STOP_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  tcw_req_t    req,
    output logic        done,
    output tcw_result_t result,
    input  logic        attr_we,
    input  logic [7:0]  attr_wdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_SCROLL = 2'd2;
    localparam logic [1:0] S_BLANK  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic              copy_vld_reg, copy_vld_next;
    logic [CELL_W-1:0] fill_val_reg, fill_val_next;
    logic              init_reg, init_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              done_reg, done_next;
    tcw_result_t       result_reg, result_next;
    logic [7:0]        attr_reg;

    logic              accept;
    tcw_cursor_cmd_t   cur_cmd;
    tcw_cursor_stat_t  cur_stat;
    logic [AW-1:0]     cur_wr_addr, cur_pos_now, cur_pos_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;
    logic [CELL_W-1:0] blank_cell;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && (state_reg == S_IDLE);
    assign blank_cell = {attr_reg, CHR_SPACE};

    assign cur_cmd.put  = accept && (req.req_type == REQ_PUT);
    assign cur_cmd.home = accept && (req.req_type == REQ_CLEAR);
    assign cur_cmd.code = req.char_code;

    tcw_cursor #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_cursor (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cur_cmd),
        .stat     (cur_stat),
        .wr_addr  (cur_wr_addr),
        .pos_now  (cur_pos_now),
        .pos_next (cur_pos_next)
    );

    tcw_cell_ram #(
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wr_ptr_reg;
        ram_wdata = fill_val_reg;
        priority if (cur_stat.wr_en)
        begin
            ram_we    = 1'b1;
            ram_waddr = cur_wr_addr;
            ram_wdata = {attr_reg, req.char_code};
        end
        else if (copy_vld_reg)
        begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
        end
        else if (state_reg == S_BLANK)
        begin
            ram_we = 1'b1;
        end
        else
        begin
            ram_we = 1'b0;
        end
        ram_raddr = (state_reg == S_SCROLL) ? sweep_reg : AW'(req.cell_index);
    end

    always_comb
    begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        wr_ptr_next   = wr_ptr_reg;
        fill_val_next = fill_val_reg;
        init_next     = init_reg;
        rd_ok_next    = rd_ok_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        copy_vld_next = (state_reg == S_SCROLL);

        if (copy_vld_reg || (state_reg == S_BLANK))
        begin
            wr_ptr_next = wr_ptr_reg + AW'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.req_type)
                        REQ_PUT:
                        begin
                            if (cur_stat.scroll)
                            begin
                                sweep_next    = AW'(COLUMNS);
                                wr_ptr_next   = '0;
                                fill_val_next = blank_cell;
                                state_next    = S_SCROLL;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = {POS_W'(cur_pos_next), CELL_W'(0)};
                            end
                        end
                        REQ_CLEAR:
                        begin
                            wr_ptr_next   = '0;
                            fill_val_next = blank_cell;
                            state_next    = S_BLANK;
                        end
                        REQ_READ:
                        begin
                            rd_ok_next = (32'(req.cell_index) < 32'(CELL_COUNT));
                            state_next = S_READ;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = {POS_W'(cur_pos_now), CELL_W'(0)};
                        end
                    endcase
                end
            end
            S_READ:
            begin
                done_next   = 1'b1;
                result_next = {POS_W'(cur_pos_now), rd_ok_reg ? ram_rdata : CELL_W'(0)};
                state_next  = S_IDLE;
            end
            S_SCROLL:
            begin
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(CELL_COUNT - 1))
                begin
                    state_next = S_BLANK;
                end
            end
            S_BLANK:
            begin
                if (!copy_vld_reg && (wr_ptr_reg == AW'(CELL_COUNT - 1)))
                begin
                    state_next = S_IDLE;
                    init_next  = 1'b0;
                    if (!init_reg)
                    begin
                        done_next   = 1'b1;
                        result_next = {POS_W'(cur_pos_now), CELL_W'(0)};
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_BLANK;
            sweep_reg    <= '0;
            wr_ptr_reg   <= '0;
            copy_vld_reg <= 1'b0;
            fill_val_reg <= {ATTR_RESET, CHR_SPACE};
            init_reg     <= 1'b1;
            rd_ok_reg    <= 1'b0;
            done_reg     <= 1'b0;
            attr_reg     <= ATTR_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            wr_ptr_reg   <= wr_ptr_next;
            copy_vld_reg <= copy_vld_next;
            fill_val_reg <= fill_val_next;
            init_reg     <= init_next;
            rd_ok_reg    <= rd_ok_next;
            done_reg     <= done_next;
            if (attr_we)
            begin
                attr_reg <= attr_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past((state_reg != S_IDLE) || accept))
        else $error("result strobe without a transfer in flight");

    a_copy_distance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCROLL) && copy_vld_reg
            |-> sweep_reg == AW'(wr_ptr_reg + AW'(COLUMNS + 1)))
        else $error("scroll copy pointers out of step");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_pos_now) < 32'(CELL_COUNT))
        else $error("cursor outside the screen");
`endif

endmodule

>>> src/tcw_cell_ram.sv
// tcw_cell_ram: cell store, one write port and one registered read port
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_cell_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH = COLUMNS_DEF * ROWS_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [CELL_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [CELL_W-1:0]        rdata
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/tcw_cursor.sv
// tcw_cursor: cursor column, row, row base and tab phase with put decoding
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_cursor
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int ROWS     = ROWS_DEF,
    parameter int TAB_STOP = TAB_STOP_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  tcw_cursor_cmd_t                    cmd,
    output tcw_cursor_stat_t                   stat,
    output logic [$clog2(COLUMNS*ROWS)-1:0]    wr_addr,
    output logic [$clog2(COLUMNS*ROWS)-1:0]    pos_now,
    output logic [$clog2(COLUMNS*ROWS)-1:0]    pos_next
);

    localparam int AW    = $clog2(COLUMNS * ROWS);
    localparam int COL_W = $clog2(COLUMNS + TAB_STOP);
    localparam int ROW_W = $clog2(ROWS + 1);
    localparam int PH_W  = $clog2(TAB_STOP);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic             row_inc;

    always_comb
    begin
        col_next    = col_reg;
        phase_next  = phase_reg;
        row_inc     = 1'b0;
        stat.wr_en  = 1'b0;
        stat.scroll = 1'b0;
        if (cmd.put)
        begin
            priority if (cmd.code == CHR_BS)
            begin
                if (col_reg != '0)
                begin
                    col_next   = col_reg - COL_W'(1);
                    phase_next = (phase_reg == '0) ? PH_W'(TAB_STOP - 1)
                                                   : phase_reg - PH_W'(1);
                end
            end
            else if (cmd.code == CHR_TAB)
            begin
                col_next   = col_reg + COL_W'(TAB_STOP - int'(phase_reg));
                phase_next = '0;
            end
            else if (cmd.code == CHR_CR)
            begin
                col_next   = '0;
                phase_next = '0;
            end
            else if (cmd.code == CHR_LF)
            begin
                col_next   = '0;
                phase_next = '0;
                row_inc    = 1'b1;
            end
            else if (cmd.code >= CHR_SPACE)
            begin
                stat.wr_en = 1'b1;
                col_next   = col_reg + COL_W'(1);
                phase_next = (phase_reg == PH_W'(TAB_STOP - 1)) ? '0
                                                                : phase_reg + PH_W'(1);
            end
            else
            begin
                col_next = col_reg;
            end
            if (col_next >= COL_W'(COLUMNS))
            begin
                col_next   = '0;
                phase_next = '0;
                row_inc    = 1'b1;
            end
        end
        stat.scroll = row_inc && (row_reg == ROW_W'(ROWS - 1));
        if (stat.scroll)
        begin
            row_next  = row_reg;
            base_next = base_reg;
        end
        else if (row_inc)
        begin
            row_next  = row_reg + ROW_W'(1);
            base_next = base_reg + AW'(COLUMNS);
        end
        else
        begin
            row_next  = row_reg;
            base_next = base_reg;
        end
        if (cmd.home)
        begin
            col_next   = '0;
            row_next   = '0;
            base_next  = '0;
            phase_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            base_reg  <= '0;
            phase_reg <= '0;
        end
        else if (cmd.put || cmd.home)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            base_reg  <= base_next;
            phase_reg <= phase_next;
        end
    end

    assign wr_addr  = base_reg + AW'(col_reg);
    assign pos_now  = base_reg + AW'(col_reg);
    assign pos_next = base_next + AW'(col_next);

endmodule

>>> tb/sv/tb.sv
// tb: self-checking bench for text_console_char_writer, with a driver, a monitor and a
// shadow console that predicts every result. directed then random put/clear/read/unused traffic
// depends on tcw_pkg and text_console_char_writer
`timescale 1ns / 1ps

module tb;
    import tcw_pkg::*;

    localparam int COLUMNS     = COLUMNS_DEF;
    localparam int ROWS        = ROWS_DEF;
    localparam int TAB_STOP    = TAB_STOP_DEF;
    localparam int CELL_COUNT  = COLUMNS * ROWS;
    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int TAIL_CYCLES = 2100;
    localparam int PHASE_ITEMS = 230;
    localparam int MAX_REPORTS = 40;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    tcw_req_t    req = '0;
    logic        done;
    tcw_result_t result;
    logic        attr_we = 1'b0;
    logic [7:0]  attr_wdata = '0;

    logic [CELL_W-1:0] shadow_cells [0:CELL_COUNT-1];
    int unsigned       shadow_col;
    int unsigned       shadow_row;
    logic [7:0]        shadow_attr;

    tcw_req_t    queued_reqs[$];
    tcw_result_t pending_results[$];
    tcw_result_t oldest;
    int          xfer_count = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    logic        hold_off;

    text_console_char_writer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .result     (result),
        .attr_we    (attr_we),
        .attr_wdata (attr_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic tcw_result_t next_console_result(tcw_req_t r);
        tcw_result_t res;
        int          i;
        res.cell_data = '0;
        case (r.req_type)
            REQ_PUT:
            begin
                if (r.char_code == CHR_BS)
                begin
                    if (shadow_col != 0)
                        shadow_col--;
                end
                else if (r.char_code == CHR_TAB)
                    shadow_col = (shadow_col / TAB_STOP + 1) * TAB_STOP;
                else if (r.char_code == CHR_CR)
                    shadow_col = 0;
                else if (r.char_code == CHR_LF)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                else if (r.char_code >= CHR_SPACE)
                begin
                    shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_attr, r.char_code};
                    shadow_col++;
                end
                if (shadow_col >= COLUMNS)
                begin
                    shadow_col = 0;
                    shadow_row++;
                end
                if (shadow_row >= ROWS)
                begin
                    for (i = 0; i < CELL_COUNT - COLUMNS; i++)
                        shadow_cells[i] = shadow_cells[i + COLUMNS];
                    for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                        shadow_cells[i] = {shadow_attr, CHR_SPACE};
                    shadow_row = ROWS - 1;
                end
            end
            REQ_CLEAR:
            begin
                for (i = 0; i < CELL_COUNT; i++)
                    shadow_cells[i] = {shadow_attr, CHR_SPACE};
                shadow_col = 0;
                shadow_row = 0;
            end
            REQ_READ:
            begin
                if (r.cell_index < CELL_COUNT)
                    res.cell_data = shadow_cells[r.cell_index];
            end
            default:
            begin
            end
        endcase
        res.cursor_pos = POS_W'(shadow_row * COLUMNS + shadow_col);
        return res;
    endfunction

    function automatic tcw_req_t random_req();
        tcw_req_t    r;
        int unsigned pick;
        int unsigned spot;
        r.req_type   = REQ_PUT;
        r.char_code  = 8'($urandom);
        r.cell_index = IDX_W'($urandom);
        pick = $urandom_range(0, 999);
        if (pick < 3)
            r.req_type = REQ_CLEAR;
        else if (pick < 13)
            r.req_type = REQ_UNUSED;
        else if (pick < 263)
        begin
            r.req_type = REQ_READ;
            spot = $urandom_range(0, 99);
            if (spot < 10)
                r.cell_index = IDX_W'($urandom_range(CELL_COUNT, (1 << IDX_W) - 1));
            else if (spot < 55)
                r.cell_index = IDX_W'($urandom_range(0, CELL_COUNT - 1));
            else
                r.cell_index = IDX_W'($urandom_range(CELL_COUNT - 2 * COLUMNS, CELL_COUNT - 1));
        end
        else if (pick < 343)
            r.char_code = CHR_LF;
        else if (pick < 363)
            r.char_code = CHR_CR;
        else if (pick < 403)
            r.char_code = CHR_BS;
        else if (pick < 453)
            r.char_code = CHR_TAB;
        else if (pick < 473)
            r.char_code = 8'($urandom_range(0, CHR_SPACE - 1));
        else
            r.char_code = 8'($urandom_range(CHR_SPACE, 255));
        return r;
    endfunction

    task automatic push_req(logic [1:0] kind, logic [7:0] code, logic [IDX_W-1:0] idx);
        tcw_req_t r;
        r.req_type   = kind;
        r.char_code  = code;
        r.cell_index = idx;
        queued_reqs.push_back(r);
    endtask

    // settled values are checked between edges, the caller resumes at a rising edge
    task automatic wait_idle();
        @(negedge clk);
        while (queued_reqs.size() != 0 || pending_results.size() != 0 || start || busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_attribute(logic [7:0] value);
        wait_idle();
        attr_we    <= 1'b1;
        attr_wdata <= value;
        shadow_attr = value;
        @(posedge clk);
        attr_we <= 1'b0;
    endtask

    // transfer: start high and busy low at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                pending_results.push_back(next_console_result(req));
                xfer_count <= xfer_count + 1;
            end
            if (!(start && busy))
            begin
                hold_off = (xfer_count < 300 || xfer_count >= 600) && $urandom_range(0, 99) < 11;
                if (queued_reqs.size() != 0 && !hold_off)
                begin
                    start <= 1'b1;
                    req   <= queued_reqs.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual pos %0d data %h",
                             $time, result.cursor_pos, result.cell_data);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (result.cursor_pos !== oldest.cursor_pos)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: cursor_pos mismatch, expected %0d, actual %0d",
                                 $time, oldest.cursor_pos, result.cursor_pos);
                end
                if (result.cell_data !== oldest.cell_data)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: cell_data mismatch, expected %h, actual %h",
                                 $time, oldest.cell_data, result.cell_data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] phase_attr [0:4];
        int         p;
        int         n;
        phase_attr[0] = 8'hFF;
        phase_attr[1] = 8'h00;
        phase_attr[2] = 8'($urandom);
        phase_attr[3] = 8'h70;
        phase_attr[4] = 8'($urandom);
        for (n = 0; n < CELL_COUNT; n++)
            shadow_cells[n] = {ATTR_RESET, CHR_SPACE};
        shadow_col  = 0;
        shadow_row  = 0;
        shadow_attr = ATTR_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset contents, range edges, cursor controls, ignored bytes, an unused request, a clear
        push_req(REQ_READ, 8'h00, IDX_W'(0));
        push_req(REQ_READ, 8'h00, IDX_W'(CELL_COUNT - 1));
        push_req(REQ_READ, 8'h00, IDX_W'(CELL_COUNT));
        push_req(REQ_READ, 8'hFF, '1);
        push_req(REQ_PUT, 8'h41, '0);
        push_req(REQ_PUT, 8'hFF, '1);
        push_req(REQ_PUT, CHR_SPACE, '0);
        push_req(REQ_PUT, CHR_BS, '0);
        push_req(REQ_PUT, CHR_CR, '0);
        push_req(REQ_PUT, CHR_BS, '0);
        push_req(REQ_PUT, CHR_TAB, '0);
        push_req(REQ_PUT, CHR_TAB, '0);
        push_req(REQ_PUT, 8'h00, '0);
        push_req(REQ_PUT, 8'h1F, '0);
        push_req(REQ_PUT, CHR_LF, '0);
        push_req(REQ_UNUSED, 8'hFF, '1);
        push_req(REQ_READ, 8'h00, IDX_W'(0));
        push_req(REQ_READ, 8'h00, IDX_W'(1));
        push_req(REQ_READ, 8'h00, IDX_W'(2));
        push_req(REQ_CLEAR, 8'hFF, '1);
        push_req(REQ_READ, 8'h00, IDX_W'(0));

        for (p = 0; p < 5; p++)
        begin
            write_attribute(phase_attr[p]);
            if (p == 1 || p == 3)
                push_req(REQ_CLEAR, 8'($urandom), IDX_W'($urandom));
            for (n = 0; n < PHASE_ITEMS; n++)
                queued_reqs.push_back(random_req());
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
src/tcw_pkg.sv
src/tcw_cell_ram.sv
src/tcw_cursor.sv
src/text_console_char_writer.sv
tb/sv/tb.sv
